FILE: rtl/q16md_pkg.sv
package q16md_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_RAW = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam int unsigned DIV_BITS = 64;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // what one divider cell hands to the next
  typedef struct packed {
    logic        vld;
    op_t         op;
    logic [127:0] rq;   // partial remainder : numerator / quotient bits
    logic [63:0] den;   // divisor magnitude
    logic        qneg;  // signs differ
    logic        nneg;  // numerator negative
    logic        dz;    // zero divisor
  } div_cell_t;

endpackage

FILE: rtl/q16md_req_if.sv
interface q16md_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

FILE: rtl/q16md_res_if.sv
interface q16md_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

FILE: rtl/q16md_div_cell.sv
module q16md_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  q16md_pkg::div_cell_t din,
  output q16md_pkg::div_cell_t dout
);
  import q16md_pkg::*;

  logic [63:0] part;
  logic [64:0] diff;
  div_cell_t   nxt;

  // one restoring step: shift in next numerator bit, subtract if it fits
  always_comb begin
    part = din.rq[126:63];
    diff = {1'b0, part} - {1'b0, din.den};
    nxt = din;
    if (!diff[64]) begin
      nxt.rq = {diff[63:0], din.rq[62:0], 1'b1};
    end else begin
      nxt.rq = {part, din.rq[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.op   <= nxt.op;
      dout.rq   <= nxt.rq;
      dout.den  <= nxt.den;
      dout.qneg <= nxt.qneg;
      dout.nneg <= nxt.nneg;
      dout.dz   <= nxt.dz;
    end
  end
endmodule

FILE: rtl/q16_rounded_mul_div_unit.sv
// Signed Q16.16 multiply / divide unit with round half away from zero and
// saturation to the signed 32-bit range (req_type 2: raw 64-bit divide).
// req channel: req_type, operand_a, operand_b; res channel: result.
// Each transfer on req gives exactly one transfer on res, in order.
// From request transfer to result valid a request passes one input
// cell forming magnitudes, one cell with the 32x32 multiplier and operand
// select, 64 restoring divider cells (one quotient bit each) and one
// rounding / saturation cell that is the output register.
// Throughput is one request per cycle while the receiver does not stall;
// every operation, multiply included, runs through the same divider chain
// (multiply divides by 2^FRAC_BITS). Zero denominators give the max result
// for a non-negative numerator and the min otherwise; req_type 3 gives zero.
// Reset clears all valid bits; the chain is empty afterwards.
// When the receiver stalls the whole chain holds and req.ready drops, so
// up to 67 requests are kept in flight without loss.
module q16_rounded_mul_div_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  q16md_req_if.sink   req,
  q16md_res_if.source res
);
  import q16md_pkg::*;

  logic en;
  assign en = !res.valid || res.ready;
  assign req.ready = en;

  // input cell: magnitudes and signs
  logic        a_vld;
  op_t         a_op;
  logic [31:0] a_ma32, a_mb32;
  logic        a_sa32, a_sb32, a_zb32;
  logic [63:0] a_ma64, a_mb64;
  logic        a_sa64, a_sb64, a_zb64;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= req.valid;
    end
    if (en) begin
      a_op   <= op_t'(req.req_type);
      a_sa32 <= req.operand_a[31];
      a_sb32 <= req.operand_b[31];
      a_ma32 <= req.operand_a[31] ? 32'd0 - req.operand_a[31:0] : req.operand_a[31:0];
      a_mb32 <= req.operand_b[31] ? 32'd0 - req.operand_b[31:0] : req.operand_b[31:0];
      a_zb32 <= (req.operand_b[31:0] == 32'd0);
      a_sa64 <= req.operand_a[63];
      a_sb64 <= req.operand_b[63];
      a_ma64 <= req.operand_a[63] ? 64'd0 - req.operand_a : req.operand_a;
      a_mb64 <= req.operand_b[63] ? 64'd0 - req.operand_b : req.operand_b;
      a_zb64 <= (req.operand_b == 64'sd0);
    end
  end

  // operand cell: product and divider operands
  div_cell_t   cells [0:DIV_BITS];
  div_cell_t   prep;
  logic [63:0] prod;

  always_comb begin
    prod = {32'd0, a_ma32} * {32'd0, a_mb32};
    prep = '0;
    prep.vld = a_vld;
    prep.op  = a_op;
    case (a_op)
      OP_MUL: begin
        prep.rq   = {64'd0, prod};
        prep.den  = 64'd1 << FRAC_BITS;
        prep.qneg = a_sa32 ^ a_sb32;
        prep.nneg = a_sa32 ^ a_sb32;
        prep.dz   = 1'b0;
      end
      OP_DIV: begin
        prep.rq   = {64'd0, {32'd0, a_ma32} << FRAC_BITS};
        prep.den  = {32'd0, a_mb32};
        prep.qneg = a_sa32 ^ a_sb32;
        prep.nneg = a_sa32;
        prep.dz   = a_zb32;
      end
      OP_RAW: begin
        prep.rq   = {64'd0, a_ma64};
        prep.den  = a_mb64;
        prep.qneg = a_sa64 ^ a_sb64;
        prep.nneg = a_sa64;
        prep.dz   = a_zb64;
      end
      default: begin
        prep.rq  = '0;
        prep.den = 64'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells[0].vld <= 1'b0;
    end else if (en) begin
      cells[0].vld <= prep.vld;
    end
    if (en) begin
      cells[0].op   <= prep.op;
      cells[0].rq   <= prep.rq;
      cells[0].den  <= prep.den;
      cells[0].qneg <= prep.qneg;
      cells[0].nneg <= prep.nneg;
      cells[0].dz   <= prep.dz;
    end
  end

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    q16md_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (cells[k]),
      .dout (cells[k+1])
    );
  end

  // rounding and saturation cell
  div_cell_t   last;
  logic [63:0] quo, rem;
  logic        rnd;
  logic [64:0] qr;
  logic        neg;
  logic [31:0] res_next;

  always_comb begin
    last = cells[DIV_BITS];
    quo  = last.rq[63:0];
    rem  = last.rq[127:64];
    rnd  = (rem != 64'd0) && ({rem, 1'b0} >= {1'b0, last.den});
    qr   = {1'b0, quo} + {64'd0, rnd};
    neg  = last.qneg && (qr != 65'd0);
    if (last.op == OP_NONE) begin
      res_next = 32'd0;
    end else if (last.dz) begin
      res_next = last.nneg ? SAT_MIN : SAT_MAX;
    end else if (!neg) begin
      res_next = (qr > {33'd0, SAT_MAX}) ? SAT_MAX : qr[31:0];
    end else begin
      res_next = (qr > {33'd0, SAT_MIN}) ? SAT_MIN : 32'd0 - qr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= last.vld;
    end
    if (en) begin
      res.result <= res_next;
    end
  end
endmodule

FILE: rtl/q16md_checker.sv
module q16md_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] result
);
  // nothing comes out straight after reset
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result))
    else $error("stalled result changed");

  // input side stalls exactly when output is blocked
  a_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!res_valid || res_ready))
    else $error("req ready mismatch");

  // no request is taken while a result is stalled at the output
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !req_ready)
    else $error("request taken while output stalled");

  // both valids are known once out of reset
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({req_valid, res_valid}))
    else $error("valid unknown");
endmodule

bind q16_rounded_mul_div_unit q16md_checker u_q16md_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .result    (res.result)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import q16md_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = 67;

  typedef struct {
    op_t               kind;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } md_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  q16md_req_if req_ch ();
  q16md_res_if res_ch ();

  q16_rounded_mul_div_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .res(res_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  md_req_t            pending_reqs[$];
  logic signed [31:0] expected_results[$];
  int                 mismatch_count = 0;
  bit                 stimulus_done = 1'b0;
  int                 hold_cycles = 0;

  // magnitude of a 64-bit two's complement pattern
  function automatic logic [63:0] abs64(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // rounding half away from zero, saturated to 32 bits
  function automatic logic [31:0] div_round_sat(logic [63:0] num, logic [63:0] den);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    logic [63:0] r;
    logic        neg;
    if (den == 64'd0) return num[63] ? SAT_MIN : SAT_MAX;
    mn = abs64(num);
    md = abs64(den);
    q = mn / md;
    r = mn % md;
    if (r != 0 && {1'b0, r, 1'b0} >= {1'b0, 1'b0, md}) q = q + 1;
    neg = (num[63] != den[63]) && q != 0;
    if (!neg) return (q > 64'h7FFF_FFFF) ? SAT_MAX : q[31:0];
    if (q > 64'h8000_0000) return SAT_MIN;
    return 32'd0 - q[31:0];
  endfunction

  // expected Q16.16 result of one request
  function automatic logic [31:0] q16_result(md_req_t r);
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] p;
    sa = {{32{r.a[31]}}, r.a[31:0]};
    sb = {{32{r.b[31]}}, r.b[31:0]};
    case (r.kind)
      OP_MUL: begin
        p = abs64(sa) * abs64(sb);
        if (sa[63] ^ sb[63]) p = 64'd0 - p;
        return div_round_sat(p, 64'd1 << FRAC);
      end
      OP_DIV: begin
        p = abs64(sa) << FRAC;
        if (sa[63]) p = 64'd0 - p;
        return div_round_sat(p, sb);
      end
      OP_RAW: return div_round_sat(r.a, r.b);
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // operand with a bias towards edge values
  function automatic logic [63:0] pick_operand(bit narrow);
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: v = 64'd1 << $urandom_range(0, 63);
      2: v = 64'd0 - (64'd1 << $urandom_range(0, 62));
      3: v = 64'($signed($urandom_range(0, 8)) - 4);
      4: v = {{32{1'b0}}, 32'h0001_0000} * $urandom_range(0, 100);
      default: v = rand64();
    endcase
    if (narrow && $urandom_range(0, 1)) v = rand64() >> $urandom_range(0, 63);
    if (narrow && $urandom_range(0, 3) == 0) v = 64'd0 - v;
    return v;
  endfunction

  task automatic push_req(op_t k, logic [63:0] a, logic [63:0] b);
    md_req_t r;
    r.kind = k;
    r.a = a;
    r.b = b;
    pending_reqs.push_back(r);
  endtask

  // stimulus
  initial begin
    op_t k;
    // directed: extremes, every op, zero denominator, overflow, halves
    push_req(OP_MUL, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_7FFF_FFFF);
    push_req(OP_MUL, 64'hFFFF_FFFF_8000_0000, 64'hFFFF_FFFF_8000_0000);
    push_req(OP_MUL, 64'h1234_5678_8000_0000, 64'h0000_0000_7FFF_FFFF);
    push_req(OP_MUL, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_8000);
    push_req(OP_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_8000);
    push_req(OP_MUL, 64'h0000_0000_0001_0000, 64'hFFFF_FFFF_FFFE_0000);
    push_req(OP_DIV, 64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000);
    push_req(OP_DIV, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
    push_req(OP_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'hABCD_0000_0000_0000);
    push_req(OP_DIV, 64'h0000_0000_0000_0001, 64'h0000_0000_0002_0000);
    push_req(OP_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0002_0000);
    push_req(OP_DIV, 64'hFFFF_FFFF_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(OP_DIV, 64'h0000_0000_7FFF_FFFF, 64'hFFFF_FFFF_8000_0000);
    push_req(OP_RAW, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(OP_RAW, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
    push_req(OP_RAW, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
    push_req(OP_RAW, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    push_req(OP_RAW, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    push_req(OP_RAW, 64'h0000_0000_0000_0005, 64'h0000_0000_0000_0002);
    push_req(OP_RAW, 64'hFFFF_FFFF_FFFF_FFFB, 64'h0000_0000_0000_0002);
    push_req(OP_RAW, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0003);
    push_req(OP_RAW, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_0000_0001);
    push_req(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_req(OP_NONE, 64'd0, 64'd0);
    // random
    for (int i = 0; i < 1700; i++) begin
      k = ($urandom_range(0, 19) == 0) ? OP_NONE : op_t'($urandom_range(0, 2));
      push_req(k, pick_operand(k == OP_RAW), pick_operand(k == OP_RAW));
    end
    stimulus_done = 1'b1;
  end

  // request driver
  int req_gap = 0;
  int req_sent = 0;
  bit drain_done = 1'b0;
  bit req_taken;
  int sent_now;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= 2'd0;
      req_ch.operand_a <= 64'd0;
      req_ch.operand_b <= 64'd0;
      req_gap <= 0;
    end else begin
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken) begin
        expected_results.push_back(q16_result(pending_reqs.pop_front()));
        req_sent <= req_sent + 1;
      end
      sent_now = req_sent + (req_taken ? 1 : 0);
      if (req_ch.valid && !req_ch.ready) begin
        // hold the item on offer
      end else if (req_gap > 0) begin
        req_ch.valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (sent_now == 600 && !drain_done && expected_results.size() != 0) begin
        // pause once until the pipeline has emptied
        req_ch.valid <= 1'b0;
      end else begin
        if (sent_now == 600) drain_done <= 1'b1;
        if (pending_reqs.size() != 0) begin
          req_ch.valid <= 1'b1;
          req_ch.req_type <= pending_reqs[0].kind;
          req_ch.operand_a <= pending_reqs[0].a;
          req_ch.operand_b <= pending_reqs[0].b;
          req_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_cycles = 0;
    wait (req_sent >= 200);
    while (hold_cycles < 200) begin
      @(posedge clk);
      hold_cycles = hold_cycles + 1;
    end
  end

  // result monitor
  int res_gap = 0;
  logic signed [31:0] want;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_gap <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result %h", res_ch.result);
        end else begin
          want = expected_results.pop_front();
          if (res_ch.result !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("result mismatch: expected %h, got %h", want, res_ch.result);
          end
        end
      end
      if (req_sent >= 200 && hold_cycles < 200) begin
        res_ch.ready <= 1'b0;
      end else if (res_gap > 0) begin
        res_ch.ready <= 1'b0;
        res_gap <= res_gap - 1;
      end else begin
        res_ch.ready <= 1'b1;
        if (res_ch.valid && res_ch.ready)
          res_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
      end
    end
  end

  // reset and end of run
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (stimulus_done && pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
